[rtl/core/keyed_table_with_aging_unit_macros.svh]
// assertion macros for the keyed table unit
`ifndef KEYED_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define KEYED_TABLE_WITH_AGING_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define KTA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KTA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTA_ASSERT(lbl, clk, rst, prop, msg)
`define KTA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/kta_pkg.sv]
// shared types and constants for the keyed table unit
`default_nettype none
package kta_pkg;
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_BITS_DEF = 64;
  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_QUAR = 2'd2;
  localparam logic [1:0] OP_SWEEP = 2'd3;
  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_QEXIST = 3'd5;
  localparam logic [2:0] ST_QNEW = 3'd6;
  localparam logic [2:0] ST_SWEEP = 3'd7;
  // request as held in the queue
  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [31:0] ip_addr;
    logic        has_ip;
    logic [15:0] port_num;
    logic [63:0] identity_word;
    logic        has_identity;
    logic [7:0]  reason_code;
    logic [31:0] now_time;
  } req_t;
  // one table entry, key excluded
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] ident;
    logic [31:0] seen;
    logic        quar;
    logic        active;
    logic [7:0]  why;
  } ent_t;
  localparam int ENT_W = $bits(ent_t);
endpackage
`default_nettype wire

[rtl/core/keyed_table_with_aging_unit.sv]
// top level of the keyed table unit with aging
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    opcode .. now_time
// out      output     out_valid/out_stall  status .. entry_reason
// cfg      input      cfg_we               cfg_data (stale_limit)
//
// a lookup reads one entry at a time through the single-port rams (read, check),
// stopping at the first match or at the end of the entries in use
// a sweep visits each entry in use in turn (read, check, write back)
// the queue takes two requests while the back end scans
// reset clears the count and control; entry rams hold no reset
// out_stall holds the result in place until taken
`default_nettype none
`include "keyed_table_with_aging_unit_macros.svh"
module keyed_table_with_aging_unit import kta_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] ip_addr,
  input  wire logic        has_ip,
  input  wire logic [15:0] port_num,
  input  wire logic [63:0] identity_word,
  input  wire logic        has_identity,
  input  wire logic [7:0]  reason_code,
  input  wire logic [31:0] now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [4:0]       slot,
  output logic [31:0]      entry_ip,
  output logic [15:0]      entry_port,
  output logic [63:0]      entry_identity,
  output logic [31:0]      entry_seen,
  output logic             entry_active,
  output logic             entry_quarantined,
  output logic [7:0]       entry_reason
);
  logic [31:0] stale_limit;
  logic q_full, q_push, q_pop, q_ne;
  req_t push_req, head;
  ent_t res;

  // age limit register
  always_ff @(posedge clk) begin
    if (rst) stale_limit <= 32'd60;
    else if (cfg_we) stale_limit <= cfg_data;
  end

  kta_front #(.KEY_BITS(KEY_BITS)) u_front (
    .in_valid, .in_stall, .opcode, .key, .ip_addr, .has_ip, .port_num,
    .identity_word, .has_identity, .reason_code, .now_time,
    .q_full, .push(q_push), .push_req);

  kta_queue u_queue (
    .clk, .rst, .push(q_push), .push_req, .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head);

  kta_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk, .rst, .stale_limit, .q_valid(q_ne), .q_head(head), .q_pop,
    .out_valid, .out_stall, .status, .slot, .res);

  assign entry_ip = res.addr;
  assign entry_port = res.port;
  assign entry_identity = res.ident;
  assign entry_seen = res.seen;
  assign entry_active = res.active;
  assign entry_quarantined = res.quar;
  assign entry_reason = res.why;

  // a held result must not change
  `KTA_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(status), "result changed while stalled")
  // queue never pushed when full
  `KTA_ASSERT(a_qfull, clk, rst, q_full |-> !q_push, "push into full queue")
  // reset leaves no result pending
  `KTA_ASSERT_RST(a_rst, clk, rst |=> !out_valid, "result after reset")
endmodule
`default_nettype wire

[rtl/core/kta_ram.sv]
// generic single port ram with registered read
`default_nettype none
module kta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/kta_queue.sv]
// two-entry request queue between front and back
`default_nettype none
module kta_queue import kta_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  req_t      push_req,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output req_t      head
);
  req_t buf_q [2];
  logic rd, wr;
  logic [1:0] cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) buf_q[wr] <= push_req;
  end
  assign full = cnt[1];
  assign not_empty = cnt != 2'd0;
  assign head = buf_q[rd];
endmodule
`default_nettype wire

[rtl/core/kta_front.sv]
// front end: takes requests, masks key, pushes to queue
`default_nettype none
module kta_front import kta_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] ip_addr,
  input  wire logic        has_ip,
  input  wire logic [15:0] port_num,
  input  wire logic [63:0] identity_word,
  input  wire logic        has_identity,
  input  wire logic [7:0]  reason_code,
  input  wire logic [31:0] now_time,
  input  wire logic        q_full,
  output logic             push,
  output req_t             push_req
);
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
  assign in_stall = q_full;
  assign push = in_valid & ~q_full;
  always_comb begin
    push_req.opcode = opcode;
    push_req.key = key & KEY_MASK;
    push_req.ip_addr = ip_addr;
    push_req.has_ip = has_ip;
    push_req.port_num = port_num;
    push_req.identity_word = identity_word;
    push_req.has_identity = has_identity;
    push_req.reason_code = reason_code;
    push_req.now_time = now_time;
  end
endmodule
`default_nettype wire

[rtl/core/kta_back.sv]
// back end: scans the table and writes back at most one entry, or each entry on a sweep
`default_nettype none
module kta_back import kta_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] stale_limit,
  input  wire logic        q_valid,
  input  req_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [4:0]       slot,
  output ent_t             res
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CHK = 3'd2,
                         S_WR = 3'd3, S_OUT = 3'd4;

  logic [2:0] state;
  logic [CW-1:0] count, idx;
  req_t req;
  logic [2:0] st;
  logic [AW-1:0] waddr;
  logic key_we, ent_we, shown;
  ent_t went, rent;
  logic [63:0] rkey;
  logic [AW-1:0] ram_addr;
  logic hit, stale, can_app;
  logic [31:0] age;
  ent_t hit_ent, sweep_ent, app_ent;
  logic [2:0] hit_st, app_st;

  assign ram_addr = (state == S_WR) ? waddr : idx[AW-1:0];
  kta_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_key (
    .clk, .we(key_we & (state == S_WR)), .addr(ram_addr), .wdata(req.key), .rdata(rkey));
  kta_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent (
    .clk, .we(ent_we & (state == S_WR)), .addr(ram_addr), .wdata(went), .rdata(rent));

  assign hit = (rkey == req.key) & (rent.active | (req.opcode == OP_QUAR));
  assign age = req.now_time - rent.seen;
  assign stale = rent.active & ~rent.quar & (age > stale_limit);
  assign can_app = ((req.opcode == OP_UPSERT) || (req.opcode == OP_QUAR)) &&
                   (count != MAX_C);
  assign q_pop = (state == S_IDLE) & q_valid;
  assign out_valid = state == S_OUT;

  // entry as left by one sweep visit
  always_comb begin
    sweep_ent = rent;
    if (stale) sweep_ent.active = 1'b0;
  end

  // entry and status on a matching key
  always_comb begin
    hit_ent = rent;
    hit_st = ST_FOUND;
    unique case (req.opcode)
      OP_UPSERT: begin
        hit_st = ST_UPDATED;
        hit_ent.port = req.port_num;
        hit_ent.seen = req.now_time;
        if (req.has_ip) hit_ent.addr = req.ip_addr;
        if (req.has_identity) hit_ent.ident = req.identity_word;
      end
      OP_QUAR: begin
        hit_st = ST_QEXIST;
        hit_ent.active = 1'b0;
        hit_ent.quar = 1'b1;
        hit_ent.why = req.reason_code;
      end
      default: ;
    endcase
  end

  // new entry and status at the end of a scan without a match
  always_comb begin
    app_ent = '0;
    app_st = ST_SWEEP;
    unique case (req.opcode)
      OP_UPSERT: begin
        app_st = can_app ? ST_INSERTED : ST_FULL;
        app_ent.active = 1'b1;
        app_ent.port = req.port_num;
        app_ent.seen = req.now_time;
        if (req.has_ip) app_ent.addr = req.ip_addr;
        if (req.has_identity) app_ent.ident = req.identity_word;
      end
      OP_GET: app_st = ST_NOTFOUND;
      OP_QUAR: begin
        app_st = can_app ? ST_QNEW : ST_FULL;
        app_ent.quar = 1'b1;
        app_ent.why = req.reason_code;
      end
      default: app_st = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; key_we <= 1'b0; ent_we <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          req <= q_head; idx <= '0; key_we <= 1'b0; ent_we <= 1'b0; state <= S_RD;
        end
        S_RD: if (idx < count) begin
          state <= S_CHK;
        end else begin
          // end of scan without a match: append or report
          waddr <= count[AW-1:0]; went <= app_ent; st <= app_st;
          key_we <= can_app; ent_we <= can_app; shown <= can_app;
          if (can_app) count <= count + CW'(1);
          state <= S_WR;
        end
        S_CHK: if (req.opcode == OP_SWEEP) begin
          waddr <= idx[AW-1:0]; went <= sweep_ent; key_we <= 1'b0; ent_we <= 1'b1;
          state <= S_WR;
        end else if (hit) begin
          waddr <= idx[AW-1:0]; went <= hit_ent; st <= hit_st;
          key_we <= 1'b0; ent_we <= 1'b1; shown <= 1'b1;
          idx <= MAX_C; state <= S_WR;
        end else begin
          idx <= idx + CW'(1); state <= S_RD;
        end
        S_WR: if (req.opcode == OP_SWEEP && idx < count) begin
          idx <= idx + CW'(1); state <= S_RD;
        end else begin
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // not found, full and sweep report no entry
  assign status = st;
  assign slot = shown ? 5'(waddr) : 5'd0;
  assign res = shown ? went : '0;
endmodule
`default_nettype wire
